>>> rtl/core/qsst_pkg.sv
// ----------------------------------------------------------------------------
// qsst_pkg
// Shared types and constants for the queued scancode serial transmitter.
// ----------------------------------------------------------------------------
package qsst_pkg;

    // Default queue depth (one slot always stays empty)
    localparam int FIFO_DEPTH_DEF = 16;

    // Data bits per frame
    localparam int FRAME_BITS = 8;

    // Saturation value of the reported queue fill
    localparam logic [3:0] QUEUED_MAX = 4'd15;

    // Input operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_FALL = 1'b1;

    // Frame phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_DATA   = 3'd2,
        PH_STOP   = 3'd3,
        PH_RETURN = 3'd4
    } t_phase;

    // One input item
    typedef struct packed {
        logic       op;
        logic [7:0] scancode;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic       data_level;
        logic       dropped;
        logic       busy_res;
        logic [3:0] queued;
    } t_out_item;

endpackage

>>> rtl/core/queued_scancode_serial_tx.sv
// ----------------------------------------------------------------------------
// queued_scancode_serial_tx
// Byte transmitter fed from a ring queue, stepped by the partner's falling
// clock edges: sync high, start 0, eight data bits LSB first, stop 1, low.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// One item per cycle unless stalled; each item yields one result in the next cycle.
// The queue lives in a RAM with registered read; the frame byte is loaded
// from its read register while the frame is in the start phase, with a
// bypass for a byte that is written and read in the same cycle.
// Reset (synchronous, active low) empties the queue and idles the line low.
// A stalled result holds in the output register; input stalls only while
// that register is full and stalled.
// ----------------------------------------------------------------------------
module queued_scancode_serial_tx #(
    parameter int FIFO_DEPTH = qsst_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  qsst_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output qsst_pkg::t_out_item  o_out_data
);

    localparam int AW = $clog2(FIFO_DEPTH);

    // Control state
    qsst_pkg::t_phase r_phase, n_phase;
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [3:0]       r_bit_count, n_bit_count;
    logic             r_line, n_line;
    logic             r_load;
    logic             r_out_valid;

    // Payload state
    logic [7:0]          r_shift_byte;
    logic [7:0]          r_fwd_data;
    logic                r_fwd_sel;
    qsst_pkg::t_out_item r_out, n_out;

    // Access controls
    logic          w_acc;
    logic          w_ram_we;
    logic          w_ram_re;
    logic [7:0]    w_ram_rd_data;
    logic [AW-1:0] w_wr_next;
    logic [AW-1:0] w_rd_next;
    logic [AW:0]   w_fill;
    logic [8:0]    w_fill_ext;
    logic          w_drop;

    // Accept while the output register is free or draining
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;

    // Ring successors
    assign w_wr_next = (r_wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
    assign w_rd_next = (r_rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);

    // Queue storage
    qsst_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH),
        .AW    (AW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (i_in_data.scancode),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (w_ram_rd_data)
    );

    // Next state, queue access and result for the current item
    always_comb begin
        n_phase     = r_phase;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_bit_count = r_bit_count;
        n_line      = r_line;
        w_ram_we    = 1'b0;
        w_ram_re    = 1'b0;
        w_drop      = 1'b0;

        if (w_acc) begin
            if (i_in_data.op == qsst_pkg::OP_PUSH) begin
                if (w_wr_next == r_rd_ptr) begin
                    w_drop = 1'b1;
                end else begin
                    w_ram_we = 1'b1;
                    n_wr_ptr = w_wr_next;
                    if (r_phase == qsst_pkg::PH_IDLE) begin
                        w_ram_re = 1'b1;
                        n_rd_ptr = w_rd_next;
                        n_line   = 1'b1;
                        n_phase  = qsst_pkg::PH_START;
                    end
                end
            end else begin
                unique case (r_phase)
                    qsst_pkg::PH_START: begin
                        n_line      = 1'b0;
                        n_phase     = qsst_pkg::PH_DATA;
                        n_bit_count = '0;
                    end
                    qsst_pkg::PH_DATA: begin
                        n_line      = r_shift_byte[r_bit_count[2:0]];
                        n_bit_count = r_bit_count + 4'd1;
                        if (n_bit_count >= 4'(qsst_pkg::FRAME_BITS)) begin
                            n_phase = qsst_pkg::PH_STOP;
                        end
                    end
                    qsst_pkg::PH_STOP: begin
                        n_line  = 1'b1;
                        n_phase = qsst_pkg::PH_RETURN;
                    end
                    qsst_pkg::PH_RETURN: begin
                        n_line  = 1'b0;
                        n_phase = qsst_pkg::PH_IDLE;
                        if (r_wr_ptr != r_rd_ptr) begin
                            w_ram_re = 1'b1;
                            n_rd_ptr = w_rd_next;
                            n_line   = 1'b1;
                            n_phase  = qsst_pkg::PH_START;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // Fill after this step, saturated
        if (n_wr_ptr >= n_rd_ptr) begin
            w_fill = {1'b0, n_wr_ptr} - {1'b0, n_rd_ptr};
        end else begin
            w_fill = {1'b0, n_wr_ptr} + (AW+1)'(FIFO_DEPTH) - {1'b0, n_rd_ptr};
        end
        w_fill_ext = 9'(w_fill);

        n_out.data_level = n_line;
        n_out.dropped    = w_drop;
        n_out.busy_res   = (n_phase != qsst_pkg::PH_IDLE);
        n_out.queued     = (w_fill_ext > 9'(qsst_pkg::QUEUED_MAX)) ?
                           qsst_pkg::QUEUED_MAX : w_fill_ext[3:0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= qsst_pkg::PH_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_bit_count <= '0;
            r_line      <= 1'b0;
            r_load      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_bit_count <= n_bit_count;
            r_line      <= n_line;
            r_load      <= w_ram_re;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture bypass data on each read, flagging a read that hits the entry written this cycle
    always_ff @(posedge i_clk) begin
        if (w_ram_re) begin
            r_fwd_sel  <= w_ram_we && (r_wr_ptr == r_rd_ptr);
            r_fwd_data <= i_in_data.scancode;
        end
    end

    // Load the frame byte in the cycle after the read is issued
    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_shift_byte <= r_fwd_sel ? r_fwd_data : w_ram_rd_data;
        end
    end

    // Hold the result until it is transferred
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Idle line implies an empty queue
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == qsst_pkg::PH_IDLE) |-> (r_wr_ptr == r_rd_ptr))
        else $error("idle with bytes still queued");

    // Idle line stays low
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == qsst_pkg::PH_IDLE) |-> !r_line)
        else $error("line high while idle");

    // Bit counter never passes the frame length
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'(qsst_pkg::FRAME_BITS))
        else $error("bit counter out of range");

    // Frame byte load lands while still in the start phase
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |-> (r_phase == qsst_pkg::PH_START))
        else $error("frame byte loaded outside start phase");

    // Every transfer in produces a result
    a_acc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_valid)
        else $error("result missing after input transfer");

endmodule

>>> rtl/core/qsst_ram.sv
// ----------------------------------------------------------------------------
// qsst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, held between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
